FILE: rtl/hc3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_pkg
// Shared types and modulo-26 helpers for the 3x3 Hill cipher engine.
// ----------------------------------------------------------------------------
package hc3_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned SumW    = 11;
  localparam int unsigned KeyW    = 9 * LetterW;
  localparam int unsigned PrepLen = 4;

  typedef logic [LetterW-1:0] letter_t;
  typedef letter_t [8:0]      mat_t;
  typedef letter_t [2:0]      vec_t;

  typedef enum logic {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_e;

  typedef struct packed {
    logic busy;
    logic err;
  } prep_stat_t;

  // x mod 26 for x below 2**SumW: reciprocal estimate, then one correction
  function automatic letter_t mod26(input logic [SumW-1:0] x);
    logic [SumW+8:0] prod;
    logic [6:0]      q;
    logic [SumW-1:0] r;
    prod = {9'd0, x} * (SumW + 9)'(315);
    q    = prod[SumW+8:SumW+2];
    r    = x - SumW'(q) * SumW'(26);
    if (r >= SumW'(26)) begin
      r = r - SumW'(26);
    end
    return r[LetterW-1:0];
  endfunction

  function automatic letter_t red26(input letter_t x);
    return (x >= LetterW'(26)) ? (x - LetterW'(26)) : x;
  endfunction

  // (a*b - c*d) mod 26, operands already reduced
  function automatic letter_t cross26(input letter_t a, input letter_t b,
                                      input letter_t c, input letter_t d);
    letter_t          p;
    letter_t          q;
    logic [LetterW:0] s;
    p = mod26(SumW'(a) * SumW'(b));
    q = mod26(SumW'(c) * SumW'(d));
    s = {1'b0, p} + (LetterW + 1)'(26) - {1'b0, q};
    if (s >= (LetterW + 1)'(26)) begin
      s = s - (LetterW + 1)'(26);
    end
    return s[LetterW-1:0];
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hc3_keyprep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_keyprep
// Key register and cached inverse key: reduce, adjugate, determinant, scale.
// ----------------------------------------------------------------------------
module hc3_keyprep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hc3_pkg::KeyW-1:0]  cfg_wdata_i,
  output hc3_pkg::mat_t             key_o,
  output hc3_pkg::mat_t             inv_o,
  output hc3_pkg::prep_stat_t       stat_o
);

  logic [hc3_pkg::KeyW-1:0]    key_q;
  logic [hc3_pkg::PrepLen-1:0] prep_q, prep_d;
  hc3_pkg::mat_t               m_q, m_d;
  hc3_pkg::mat_t               adj_q, adj_d;
  hc3_pkg::mat_t               inv_q, inv_d;
  hc3_pkg::letter_t            det_q, det_d;
  hc3_pkg::letter_t            dinv;
  logic                        err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= hc3_pkg::KeyW'(45'h100_0010_0001);
      prep_q <= hc3_pkg::PrepLen'(1);
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      prep_q <= prep_d;
    end
  end

  assign prep_d = cfg_we_i ? hc3_pkg::PrepLen'(1)
                           : {prep_q[hc3_pkg::PrepLen-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m_d[i] = hc3_pkg::red26(key_q[i*hc3_pkg::LetterW +: hc3_pkg::LetterW]);
    end
  end

  always_comb begin
    adj_d[0] = hc3_pkg::cross26(m_q[4], m_q[8], m_q[5], m_q[7]);
    adj_d[1] = hc3_pkg::cross26(m_q[2], m_q[7], m_q[1], m_q[8]);
    adj_d[2] = hc3_pkg::cross26(m_q[1], m_q[5], m_q[2], m_q[4]);
    adj_d[3] = hc3_pkg::cross26(m_q[5], m_q[6], m_q[3], m_q[8]);
    adj_d[4] = hc3_pkg::cross26(m_q[0], m_q[8], m_q[2], m_q[6]);
    adj_d[5] = hc3_pkg::cross26(m_q[2], m_q[3], m_q[0], m_q[5]);
    adj_d[6] = hc3_pkg::cross26(m_q[3], m_q[7], m_q[4], m_q[6]);
    adj_d[7] = hc3_pkg::cross26(m_q[1], m_q[6], m_q[0], m_q[7]);
    adj_d[8] = hc3_pkg::cross26(m_q[0], m_q[4], m_q[1], m_q[3]);
  end

  assign det_d = hc3_pkg::mod26(hc3_pkg::SumW'(m_q[0]) * hc3_pkg::SumW'(adj_q[0])
                              + hc3_pkg::SumW'(m_q[1]) * hc3_pkg::SumW'(adj_q[3])
                              + hc3_pkg::SumW'(m_q[2]) * hc3_pkg::SumW'(adj_q[6]));

  assign dinv  = hc3_pkg::inv26(det_q);
  assign err_d = (dinv == '0);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      inv_d[i] = hc3_pkg::mod26(hc3_pkg::SumW'(adj_q[i]) * hc3_pkg::SumW'(dinv));
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    adj_q <= adj_d;
    det_q <= det_d;
    inv_q <= inv_d;
    err_q <= err_d;
  end

  assign key_o       = m_q;
  assign inv_o       = inv_q;
  assign stat_o.busy = |prep_q;
  assign stat_o.err  = err_q;

endmodule

FILE: rtl/hc3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_lane
// One matrix row times the letter vector, accumulated and reduced mod 26.
// ----------------------------------------------------------------------------
module hc3_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  hc3_pkg::vec_t    row_i,
  input  hc3_pkg::vec_t    vec_i,
  output hc3_pkg::letter_t letter_o
);

  logic [hc3_pkg::SumW-1:0] sum_q, sum_d;

  assign sum_d = hc3_pkg::SumW'(row_i[0]) * hc3_pkg::SumW'(vec_i[0])
               + hc3_pkg::SumW'(row_i[1]) * hc3_pkg::SumW'(vec_i[1])
               + hc3_pkg::SumW'(row_i[2]) * hc3_pkg::SumW'(vec_i[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign letter_o = hc3_pkg::mod26(sum_q);

endmodule

FILE: rtl/hc3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_merge
// Output register: join the lane letters, zero them on a singular key.
// ----------------------------------------------------------------------------
module hc3_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          err_i,
  input  hc3_pkg::vec_t lanes_i,
  output logic          ready_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata,
  output logic          m_axis_tuser
);

  logic          valid_q, valid_d;
  hc3_pkg::vec_t data_q;
  logic          err_q;

  assign ready_o = !valid_q || m_axis_tready;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= err_i ? '0 : lanes_i;
      err_q  <= err_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, data_q[2], data_q[1], data_q[0]};
  assign m_axis_tuser  = err_q;

endmodule

FILE: rtl/hill_cipher_3x3_mod26.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26
// Hill cipher engine, 3x3 key mod 26, three row lanes and a merge register.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: letter_0/1/2, tuser: func
//   m_axis   | out       | tdata: out_letter_0/1/2, tuser: key_error
//   cfg      | in        | key_matrix, 45 bits, write-only
//
// One trigram per cycle unless the receiver or key preparation stalls.
// Reset or a key write runs key preparation (reduce, adjugate,
// determinant, inverse scale); s_axis_tready stays low during it.
// Each stage advances when the next one is empty or moving, so a stalled
// result holds only the output register while earlier stages keep filling.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hc3_pkg::KeyW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // letter_0, letter_1, letter_2, pad
  input  logic                      s_axis_tuser,  // func
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // out_letter_0/1/2, pad
  output logic                      m_axis_tuser   // key_error
);

  hc3_pkg::mat_t       key;
  hc3_pkg::mat_t       inv;
  hc3_pkg::prep_stat_t stat;

  logic                v1_q, v1_d;
  logic                v2_q, v2_d;
  logic                en1, en2, en_out;
  logic                accept;
  hc3_pkg::func_e      func1_q;
  hc3_pkg::vec_t       vec1_q;
  logic                err2_q;
  hc3_pkg::vec_t       lanes;

  hc3_keyprep u_keyprep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key),
    .inv_o       (inv),
    .stat_o      (stat)
  );

  assign en2           = !v2_q || en_out;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1 && !stat.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign v1_d          = en1 ? accept : v1_q;
  assign v2_d          = en2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func1_q   <= hc3_pkg::func_e'(s_axis_tuser);
      vec1_q[0] <= hc3_pkg::red26(s_axis_tdata[4:0]);
      vec1_q[1] <= hc3_pkg::red26(s_axis_tdata[9:5]);
      vec1_q[2] <= hc3_pkg::red26(s_axis_tdata[14:10]);
    end
    if (en2 && v1_q) begin
      err2_q <= stat.err;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_lane
    hc3_pkg::vec_t row;
    assign row = (func1_q == hc3_pkg::FUNC_DECRYPT) ? inv[3*r+2:3*r] : key[3*r+2:3*r];

    hc3_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en2 && v1_q),
      .row_i    (row),
      .vec_i    (vec1_q),
      .letter_o (lanes[r])
    );
  end

  hc3_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v2_q),
    .err_i         (err2_q),
    .lanes_i       (lanes),
    .ready_o       (en_out),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: rtl/hc3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_checker
// Port-level checks for the Hill cipher engine, bound to the top level.
// ----------------------------------------------------------------------------
module hc3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("letters not zero on key error");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:0] < 5'd26 && m_axis_tdata[9:5] < 5'd26
                      && m_axis_tdata[14:10] < 5'd26 && m_axis_tdata[15] == 1'b0)
    else $error("result letter out of range");

  a_key_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken during key preparation");

endmodule

bind hill_cipher_3x3_mod26 hc3_checker u_hc3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/hill_cipher_3x3_mod26_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26_tb
// Self-checking bench for the 3x3 mod-26 Hill cipher engine. A short table
// covers identity, wrapped, singular and classic keys; random phases follow
// with fresh keys. Table rows with fixed results are scored against those;
// the rest against an in-bench matrix model. Both stream sides idle at
// random, and the receiver holds off long enough to back the engine up.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26_tb;

  localparam int unsigned DIR_N          = 23;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 240;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT    = 3000;

  localparam logic [hc3_pkg::KeyW-1:0] KEY_IDENT =
      {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd1};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_ONES  = '1;
  localparam logic [hc3_pkg::KeyW-1:0] KEY_ZERO  = '0;
  localparam logic [hc3_pkg::KeyW-1:0] KEY_EVEN  =
      {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd2};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_THIRT =
      {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd13};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_CLASS =
      {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_WRAP  =
      {5'd27, 5'd26, 5'd26, 5'd26, 5'd27, 5'd26, 5'd26, 5'd26, 5'd27};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_NEG   =
      {5'd25, 5'd0, 5'd0, 5'd0, 5'd25, 5'd0, 5'd0, 5'd0, 5'd25};
  localparam logic [hc3_pkg::KeyW-1:0] KEY_DET5  =
      {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd5};

  typedef struct {
    hc3_pkg::letter_t lt [3];
    logic             err;
  } trigram_res_t;

  typedef struct {
    logic [hc3_pkg::KeyW-1:0] key;
    hc3_pkg::func_e           op;
    hc3_pkg::letter_t         ltr [3];
    bit                       typed;
    trigram_res_t             fixed;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [hc3_pkg::KeyW-1:0] cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [15:0]              s_axis_tdata;   // letter_0, letter_1, letter_2, pad
  logic                     s_axis_tuser;   // func
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [15:0]              m_axis_tdata;   // out_letter_0, out_letter_1, out_letter_2, pad
  logic                     m_axis_tuser;   // key_error

  trigram_res_t             expected_trigrams [$];
  trigram_res_t             blank_res;
  dir_row_t                 dir_rows [DIR_N];
  logic [hc3_pkg::KeyW-1:0] key_shadow;
  int unsigned              fail_count;
  int unsigned              quiet_cycles;
  bit                       tx_idle;
  bit                       rx_idle;
  bit                       rx_hold_req;

  hill_cipher_3x3_mod26 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // key times trigram, or inverse key times trigram, mod 26
  function automatic trigram_res_t hill_apply(input logic [hc3_pkg::KeyW-1:0] key,
                                              input hc3_pkg::func_e op,
                                              input hc3_pkg::letter_t a0,
                                              input hc3_pkg::letter_t a1,
                                              input hc3_pkg::letter_t a2);
    int m [3][3];
    int cof [3][3];
    int v [3];
    int det;
    int dinv;
    int acc;
    int r1;
    int r2;
    int c1;
    int c2;
    trigram_res_t res;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = int'(key[5*(3*i+j) +: 5]) % 26;
      end
    end
    v[0] = int'(a0) % 26;
    v[1] = int'(a1) % 26;
    v[2] = int'(a2) % 26;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (i == 0) ? 1 : 0;
        r2 = (i == 2) ? 1 : 2;
        c1 = (j == 0) ? 1 : 0;
        c2 = (j == 2) ? 1 : 2;
        cof[i][j] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
        if ((i + j) % 2 == 1) begin
          cof[i][j] = -cof[i][j];
        end
      end
    end
    det = (m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2]) % 26;
    if (det < 0) begin
      det += 26;
    end
    dinv = 0;
    for (int x = 1; x < 26; x++) begin
      if ((det * x) % 26 == 1) begin
        dinv = x;
      end
    end
    res.lt = '{5'd0, 5'd0, 5'd0};
    res.err = (dinv == 0);
    if (dinv != 0) begin
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc += ((op == hc3_pkg::FUNC_ENCRYPT) ? m[i][j] : cof[j][i] * dinv) * v[j];
        end
        acc = acc % 26;
        if (acc < 0) begin
          acc += 26;
        end
        res.lt[i] = hc3_pkg::letter_t'(acc);
      end
    end
    return res;
  endfunction

  task automatic send_trigram(input hc3_pkg::func_e op, input hc3_pkg::letter_t a0,
                              input hc3_pkg::letter_t a1, input hc3_pkg::letter_t a2,
                              input bit typed, input trigram_res_t fixed);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, a2, a1, a0};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    expected_trigrams.push_back(typed ? fixed : hill_apply(key_shadow, op, a0, a1, a2));
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and wait out every pending result
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    wait (expected_trigrams.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [hc3_pkg::KeyW-1:0] k);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_shadow  = k;
  endtask

  // receiver side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !rx_hold_req);
    end
  end

  always @(posedge clk_i) begin
    trigram_res_t     want;
    hc3_pkg::letter_t got [3];
    logic             got_err;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got[0]  = m_axis_tdata[4:0];
      got[1]  = m_axis_tdata[9:5];
      got[2]  = m_axis_tdata[14:10];
      got_err = m_axis_tuser;
      if (expected_trigrams.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: %0d %0d %0d err %0b", got[0], got[1], got[2],
                   got_err);
        end
      end else begin
        want = expected_trigrams.pop_front();
        if (got[0] !== want.lt[0] || got[1] !== want.lt[1] || got[2] !== want.lt[2] ||
            got_err !== want.err) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected %0d %0d %0d err %0b, got %0d %0d %0d err %0b",
                     want.lt[0], want.lt[1], want.lt[2], want.err,
                     got[0], got[1], got[2], got_err);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [hc3_pkg::KeyW-1:0] k;
    hc3_pkg::letter_t         ltr [3];
    hc3_pkg::func_e           op;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    fail_count    = 0;
    quiet_cycles  = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rx_hold_req   = 1'b0;
    key_shadow    = KEY_IDENT;
    blank_res.lt  = '{5'd0, 5'd0, 5'd0};
    blank_res.err = 1'b0;

    dir_rows = '{
      '{KEY_IDENT, hc3_pkg::FUNC_ENCRYPT, '{5'd0, 5'd0, 5'd0}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b0}},
      '{KEY_IDENT, hc3_pkg::FUNC_ENCRYPT, '{5'd25, 5'd25, 5'd25}, 1'b1,
        '{'{5'd25, 5'd25, 5'd25}, 1'b0}},
      '{KEY_IDENT, hc3_pkg::FUNC_ENCRYPT, '{5'd26, 5'd27, 5'd31}, 1'b1,
        '{'{5'd0, 5'd1, 5'd5}, 1'b0}},
      '{KEY_IDENT, hc3_pkg::FUNC_DECRYPT, '{5'd31, 5'd30, 5'd26}, 1'b1,
        '{'{5'd5, 5'd4, 5'd0}, 1'b0}},
      '{KEY_IDENT, hc3_pkg::FUNC_DECRYPT, '{5'd1, 5'd2, 5'd3}, 1'b1,
        '{'{5'd1, 5'd2, 5'd3}, 1'b0}},
      '{KEY_ONES, hc3_pkg::FUNC_ENCRYPT, '{5'd1, 5'd2, 5'd3}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_ONES, hc3_pkg::FUNC_DECRYPT, '{5'd31, 5'd31, 5'd31}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_ZERO, hc3_pkg::FUNC_ENCRYPT, '{5'd25, 5'd0, 5'd7}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_ZERO, hc3_pkg::FUNC_DECRYPT, '{5'd0, 5'd0, 5'd0}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_EVEN, hc3_pkg::FUNC_DECRYPT, '{5'd3, 5'd4, 5'd5}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_EVEN, hc3_pkg::FUNC_ENCRYPT, '{5'd3, 5'd4, 5'd5}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_THIRT, hc3_pkg::FUNC_ENCRYPT, '{5'd1, 5'd1, 5'd1}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_THIRT, hc3_pkg::FUNC_DECRYPT, '{5'd1, 5'd1, 5'd1}, 1'b1,
        '{'{5'd0, 5'd0, 5'd0}, 1'b1}},
      '{KEY_CLASS, hc3_pkg::FUNC_ENCRYPT, '{5'd0, 5'd2, 5'd19}, 1'b0, blank_res},
      '{KEY_CLASS, hc3_pkg::FUNC_DECRYPT, '{5'd15, 5'd14, 5'd7}, 1'b0, blank_res},
      '{KEY_CLASS, hc3_pkg::FUNC_ENCRYPT, '{5'd31, 5'd31, 5'd31}, 1'b0, blank_res},
      '{KEY_CLASS, hc3_pkg::FUNC_DECRYPT, '{5'd25, 5'd25, 5'd25}, 1'b0, blank_res},
      '{KEY_WRAP, hc3_pkg::FUNC_ENCRYPT, '{5'd7, 5'd8, 5'd9}, 1'b1,
        '{'{5'd7, 5'd8, 5'd9}, 1'b0}},
      '{KEY_WRAP, hc3_pkg::FUNC_DECRYPT, '{5'd30, 5'd8, 5'd9}, 1'b1,
        '{'{5'd4, 5'd8, 5'd9}, 1'b0}},
      '{KEY_NEG, hc3_pkg::FUNC_ENCRYPT, '{5'd1, 5'd2, 5'd3}, 1'b0, blank_res},
      '{KEY_NEG, hc3_pkg::FUNC_DECRYPT, '{5'd0, 5'd25, 5'd31}, 1'b0, blank_res},
      '{KEY_DET5, hc3_pkg::FUNC_DECRYPT, '{5'd10, 5'd20, 5'd30}, 1'b0, blank_res},
      '{KEY_DET5, hc3_pkg::FUNC_ENCRYPT, '{5'd10, 5'd20, 5'd30}, 1'b0, blank_res}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].key !== key_shadow) begin
        quiesce();
        load_key(dir_rows[i].key);
      end
      send_trigram(dir_rows[i].op, dir_rows[i].ltr[0], dir_rows[i].ltr[1],
                   dir_rows[i].ltr[2], dir_rows[i].typed, dir_rows[i].fixed);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        k = KEY_ONES;
      end else if (p == PHASES - 1) begin
        k = KEY_IDENT;
      end else begin
        // odd phases redraw until the key is invertible
        do begin
          for (int e = 0; e < 9; e++) begin
            k[5*e +: 5] = (p % 2 == 1) ? hc3_pkg::letter_t'($urandom_range(0, 25)) :
                                         hc3_pkg::letter_t'($urandom_range(0, 31));
          end
        end while (p % 2 == 1 && hill_apply(k, hc3_pkg::FUNC_ENCRYPT, '0, '0, '0).err);
      end
      quiesce();
      load_key(k);
      tx_idle = (p % 3 != 1) && (p != 2);
      rx_idle = (p != 5);
      if (p == 2) begin
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          quiesce();
        end
        op = hc3_pkg::func_e'($urandom_range(0, 1));
        for (int j = 0; j < 3; j++) begin
          ltr[j] = hc3_pkg::letter_t'($urandom_range(0, 31));
        end
        send_trigram(op, ltr[0], ltr[1], ltr[2], 1'b0, blank_res);
      end
    end

    quiesce();
    if (expected_trigrams.size() != 0) begin
      fail_count += expected_trigrams.size();
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
